// ===== rtl/slftp_pkg.sv =====
// Shared types and constants for the sync/length/type frame parser.
package slftp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 16;

    // Reset value of the buffer size register
    localparam logic [POS_W-1:0] MAX_SIZE_RESET = 16'd256;

    // Frame layout: sync at 0..2, length at 3..4, type at 5, payload from 6
    localparam logic [POS_W-1:0] SYNC_LEN    = 16'd3;
    localparam logic [POS_W-1:0] SYNC_LAST   = 16'd2;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 16'd4;
    localparam logic [POS_W-1:0] POS_TYPE    = 16'd5;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 16'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_data;
        logic [POS_W-1:0]  byte_position;
        logic              payload_valid;
        logic              frame_done;
        logic              frame_truncated;
        logic [BYTE_W-1:0] msg_type;
        logic [POS_W-1:0]  msg_length;
        logic [POS_W-1:0]  tx_index;
    } result_t;

    // Sync pattern "9h4"
    function automatic logic [BYTE_W-1:0] sync_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] val;
        unique case (idx)
            2'd0:    val = 8'h39;
            2'd1:    val = 8'h68;
            2'd2:    val = 8'h34;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/slftp_parser.sv =====
// Parser state machine with the result register.
module slftp_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  logic [slftp_pkg::BYTE_W-1:0] in_byte,
    input  logic [slftp_pkg::POS_W-1:0]  max_size,
    output slftp_pkg::result_t          result
);
    import slftp_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_TYPE    = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [BYTE_W-1:0] length_low_reg, length_low_next;
    logic [POS_W-1:0]  payload_length_reg, payload_length_next;
    logic [BYTE_W-1:0] frame_type_reg, frame_type_next;
    result_t           result_reg, result_next;

    logic             drop;
    logic             done;
    logic             trunc;
    logic             last;
    logic             limit;
    logic [POS_W-1:0] rel;
    logic [POS_W-1:0] len_out;

    always_comb begin
        phase_next          = phase_reg;
        position_next       = position_reg + 16'd1;
        length_low_next     = length_low_reg;
        payload_length_next = payload_length_reg;
        frame_type_next     = frame_type_reg;
        drop  = 1'b0;
        done  = 1'b0;
        trunc = 1'b0;
        last  = 1'b0;
        limit = 1'b0;
        rel   = position_reg - POS_PAYLOAD;

        unique case (phase_reg)
            PH_HUNT: begin
                if (position_reg >= SYNC_LEN || in_byte != sync_byte(position_reg[1:0])) begin
                    drop = 1'b1;
                end else if (position_reg == SYNC_LAST) begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (position_reg == POS_LEN_HI) begin
                    payload_length_next = {in_byte, length_low_reg};
                    if (payload_length_next == '0) begin
                        // empty frame: back to hunting, nothing else cleared
                        phase_next    = PH_HUNT;
                        position_next = '0;
                    end else if (payload_length_next > max_size) begin
                        drop = 1'b1;
                    end else begin
                        phase_next = PH_TYPE;
                    end
                end else begin
                    length_low_next = in_byte;
                end
            end
            PH_TYPE: begin
                if (position_reg == POS_TYPE) begin
                    frame_type_next = in_byte;
                    phase_next      = PH_PAYLOAD;
                end else begin
                    drop = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                // compares done one bit wider so the +1 never wraps
                last  = (payload_length_reg == '0) ||
                        ({1'b0, rel} + 17'd1 >= {1'b0, payload_length_reg});
                limit = ({1'b0, position_reg} + 17'd1 >= {1'b0, max_size});
                if (last || limit) begin
                    done  = 1'b1;
                    trunc = !last;
                    drop  = 1'b1;
                end
            end
            default: drop = 1'b1;
        endcase

        len_out = payload_length_next;
        if (drop) begin
            phase_next          = PH_HUNT;
            position_next       = '0;
            payload_length_next = '0;
        end

        result_next.byte_data       = in_byte;
        result_next.byte_position   = position_reg;
        result_next.payload_valid   = (phase_reg == PH_PAYLOAD);
        result_next.frame_done      = done;
        result_next.frame_truncated = trunc;
        result_next.msg_type        = frame_type_next;
        result_next.msg_length      = len_out;
        result_next.tx_index        = position_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HUNT;
            position_reg       <= '0;
            length_low_reg     <= '0;
            payload_length_reg <= '0;
            frame_type_reg     <= '0;
        end else if (load) begin
            phase_reg          <= phase_next;
            position_reg       <= position_next;
            length_low_reg     <= length_low_next;
            payload_length_reg <= payload_length_next;
            frame_type_reg     <= frame_type_next;
            result_reg         <= result_next;
        end
    end

    assign result = result_reg;

`ifndef SYNTHESIS
    a_end_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && done) |=> (phase_reg == PH_HUNT && position_reg == '0))
        else $error("frame end did not return to hunt at position 0");

    a_hunt_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HUNT) |-> (position_reg < SYNC_LEN))
        else $error("hunt phase beyond sync bytes");

    a_length_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LENGTH) |-> (position_reg == POS_LEN_HI - 16'd1 ||
                                     position_reg == POS_LEN_HI))
        else $error("length phase at wrong position");

    a_payload_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (position_reg >= POS_PAYLOAD &&
                                      payload_length_reg != '0))
        else $error("payload phase with bad position or length");

    a_trunc_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && trunc) |=> (result_reg.frame_done && result_reg.payload_valid))
        else $error("truncated result without frame end");
`endif

endmodule

// ===== rtl/sync_length_type_frame_parser.sv =====
// An accepted item is held in the input register, then moves to the result register
// that drives m_axis; while the output is full and stalled, it waits in the input register.
// Throughput: one item per cycle while m_axis_tready keeps the output draining;
// each byte passes one compare/count step between the input register and the result register.
// Reset (aresetn low at a clock edge) empties both stages, returns the parser
// to sync hunting at position 0 and sets max_frame_size to 256.
module sync_length_type_frame_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [slftp_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] rx_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] byte_data, [23:8] byte_position, [31:24] msg_type,
    // [47:32] msg_length, [63:48] tx_index
    output logic [63:0]                  m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,  // [0] payload_valid, [1] frame_truncated
    output logic                         m_axis_tlast,  // frame_done
    input  logic                         cfg_wr_en,
    input  logic [slftp_pkg::POS_W-1:0]  cfg_wr_data    // max_frame_size
);
    import slftp_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic [POS_W-1:0]  max_size_reg;
    logic              advance;
    result_t           result;

    // the input stage moves on whenever the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_size_reg  <= MAX_SIZE_RESET;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                max_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    slftp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .in_byte  (in_byte_reg),
        .max_size (max_size_reg),
        .result   (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {result.tx_index, result.msg_length, result.msg_type,
                            result.byte_position, result.byte_data};
    assign m_axis_tuser  = {result.frame_truncated, result.payload_valid};
    assign m_axis_tlast  = result.frame_done;

endmodule

// ===== verif/tb_sync_length_type_frame_parser.sv =====
// Self-checking testbench for the sync/length/type frame parser.
`timescale 1ns / 1ps

module tb_sync_length_type_frame_parser;

    import slftp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_ITEMS   = 211;
    localparam int NUM_SEGS    = 9;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 4;

    localparam logic [BYTE_W-1:0] SYNC_WORD [3] = '{8'h39, 8'h68, 8'h34};
    localparam int SEG_SIZES [NUM_SEGS] = '{7, 256, 65535, 12, 64, 7, 65535, 256, 30};

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_MSGTYPE,
        PH_PAYLOAD
    } parse_phase_t;

    // Tracks parser state and holds the results owed by the block, oldest first.
    class frame_scoreboard;
        result_t          pending[$];
        logic [POS_W-1:0] max_size;
        parse_phase_t     phase;
        logic [POS_W-1:0] position;
        logic [7:0]       len_low;
        logic [POS_W-1:0] pay_len;
        logic [7:0]       frame_kind;
        int               errors;
        int               n_checked;
        int               n_frames;
        int               n_trunc;

        function new();
            max_size   = MAX_SIZE_RESET;
            phase      = PH_HUNT;
            position   = '0;
            len_low    = '0;
            pay_len    = '0;
            frame_kind = '0;
            errors     = 0;
            n_checked  = 0;
            n_frames   = 0;
            n_trunc    = 0;
        endfunction

        function void set_max(logic [POS_W-1:0] v);
            max_size = v;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            result_t          r;
            logic [POS_W-1:0] pos;
            logic [POS_W-1:0] nxt;
            logic [POS_W-1:0] rel;
            bit               drop;
            bit               done;
            bit               last;
            bit               limit;
            bit               is_payload;
            pos        = position;
            nxt        = pos + 16'd1;
            drop       = 1'b0;
            done       = 1'b0;
            last       = 1'b0;
            is_payload = (phase == PH_PAYLOAD);
            case (phase)
                PH_HUNT: begin
                    // a mismatching byte is dropped, not retried as the first sync byte
                    if (pos > SYNC_LAST || b != SYNC_WORD[pos[1:0]])
                        drop = 1'b1;
                    else if (pos == SYNC_LAST)
                        phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    if (pos == POS_LEN_HI) begin
                        pay_len = {b, len_low};
                        if (pay_len == '0) begin
                            phase = PH_HUNT;
                            nxt   = '0;
                        end else if (pay_len > max_size) begin
                            drop = 1'b1;
                        end else begin
                            phase = PH_MSGTYPE;
                        end
                    end else begin
                        len_low = b;
                    end
                end
                PH_MSGTYPE: begin
                    if (pos == POS_TYPE) begin
                        frame_kind = b;
                        phase      = PH_PAYLOAD;
                    end else begin
                        drop = 1'b1;
                    end
                end
                default: begin
                    rel   = pos - POS_PAYLOAD;
                    last  = (pay_len == '0) || (({1'b0, rel} + 17'd1) >= {1'b0, pay_len});
                    // buffer limit, no wrap
                    limit = (({1'b0, pos} + 17'd1) >= {1'b0, max_size});
                    if (last || limit) begin
                        done = 1'b1;
                        drop = 1'b1;
                    end
                end
            endcase
            r.msg_length = pay_len;
            if (drop) begin
                phase   = PH_HUNT;
                nxt     = '0;
                pay_len = '0;
            end
            position          = nxt;
            r.byte_data       = b;
            r.byte_position   = pos;
            r.payload_valid   = is_payload;
            r.frame_done      = done;
            r.frame_truncated = done && !last;
            r.msg_type        = frame_kind;
            r.tx_index        = position;
            if (done) n_frames++;
            if (done && !last) n_trunc++;
            pending.push_back(r);
        endfunction

        function string fmt(result_t r);
            return $sformatf("data=%h pos=%0d pl=%b done=%b trunc=%b type=%h len=%0d tx=%0d",
                             r.byte_data, r.byte_position, r.payload_valid, r.frame_done,
                             r.frame_truncated, r.msg_type, r.msg_length, r.tx_index);
        endfunction

        function void check_result(logic [63:0] tdata, logic [1:0] tuser, logic tlast);
            result_t got;
            result_t want;
            got.byte_data       = tdata[7:0];
            got.byte_position   = tdata[23:8];
            got.msg_type        = tdata[31:24];
            got.msg_length      = tdata[47:32];
            got.tx_index        = tdata[63:48];
            got.payload_valid   = tuser[0];
            got.frame_truncated = tuser[1];
            got.frame_done      = tlast;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unexpected result, nothing pending: %s", fmt(got));
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("ERROR: result %0d mismatch", n_checked);
                    $display("  expected %s", fmt(want));
                    $display("  actual   %s", fmt(got));
                end
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_wr_en     = 1'b0;
    logic [POS_W-1:0]     cfg_wr_data   = '0;

    frame_scoreboard sb = new();

    int src_idle_pct  = 23;
    int sink_idle_pct = 62;
    int bytes_sent    = 0;
    int cur_max       = MAX_SIZE_RESET;
    int sizes_used    = 1;
    int cycle_count   = 0;

    sync_length_type_frame_parser uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [7:0] byte_data, [23:8] byte_position, [31:24] msg_type,
        // [47:32] msg_length, [63:48] tx_index
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),   // [0] payload_valid, [1] frame_truncated
        .m_axis_tlast  (m_axis_tlast),   // frame_done
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)     // max_frame_size
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // handshakes sampled at the edge where they complete
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_size(input int v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= POS_W'(v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_max(POS_W'(v));
        cur_max = v;
        sizes_used++;
    endtask

    // Header plus payload; length picked to hit normal, truncated, oversize and
    // zero cases. Some frames are cut short to leave the parser mid-frame.
    task automatic send_frame();
        logic [BYTE_W-1:0] frame_q[$];
        int len;
        int n_pay;
        int cut;
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            len = $urandom_range(16, 1);
        else if (pick < 75)
            len = (cur_max <= 80) ? $urandom_range(cur_max, (cur_max > 8) ? cur_max - 8 : 1)
                                  : $urandom_range(40, 17);
        else if (pick < 85)
            len = (cur_max < 65535) ? $urandom_range(65535, cur_max + 1) : $urandom_range(40, 1);
        else if (pick < 92)
            len = 0;
        else
            len = $urandom_range(4, 1);
        frame_q = {SYNC_WORD[0], SYNC_WORD[1], SYNC_WORD[2], len[7:0], len[15:8],
                   8'($urandom_range(255))};
        if (len != 0 && len <= cur_max) begin
            n_pay = (len <= cur_max - 6) ? len : cur_max - 6;
            repeat (n_pay) frame_q.push_back(8'($urandom_range(255)));
        end
        cut = ($urandom_range(99) < 12) ? $urandom_range(frame_q.size() - 1, 1) : frame_q.size();
        for (int i = 0; i < cut; i++) send_byte(frame_q[i]);
    endtask

    // junk, biased toward partial sync patterns
    task automatic send_noise();
        repeat ($urandom_range(6, 1))
            send_byte($urandom_range(1) ? SYNC_WORD[$urandom_range(2)] : 8'($urandom_range(255)));
    endtask

    initial begin
        logic [BYTE_W-1:0] directed_q[$];
        int seg_end;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size: full frame with extreme bytes, zero length, sync miss, oversize
        directed_q = {8'h39, 8'h68, 8'h34, 8'h02, 8'h00, 8'hFF, 8'h00, 8'hFF,
                      8'h39, 8'h68, 8'h34, 8'h00, 8'h00,
                      8'h39, 8'h00,
                      8'h39, 8'h68, 8'h34, 8'h01, 8'h01};
        foreach (directed_q[i]) send_byte(directed_q[i]);

        // smallest buffer: frame hits the limit on its first payload item
        set_size(7);
        directed_q = {8'h39, 8'h68, 8'h34, 8'h07, 8'h00, 8'h5A, 8'hA5};
        foreach (directed_q[i]) send_byte(directed_q[i]);

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg / 3)
                0: begin src_idle_pct = 23; sink_idle_pct = 62; end
                1: begin src_idle_pct = 62; sink_idle_pct = 23; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            set_size(SEG_SIZES[seg]);
            seg_end = bytes_sent + SEG_ITEMS;
            while (bytes_sent < seg_end) begin
                if ($urandom_range(99) < 75)
                    send_frame();
                else
                    send_noise();
            end
        end

        wait_idle();
        if (sb.pending.size() != 0) begin
            sb.errors++;
            $display("ERROR: %0d results never arrived", sb.pending.size());
        end
        $display("Sent %0d items over %0d buffer sizes, checked %0d results",
                 bytes_sent, sizes_used, sb.n_checked);
        $display("Frames ended: %0d, truncated at buffer limit: %0d, errors: %0d",
                 sb.n_frames, sb.n_trunc, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
